[rtl/core/mbe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and fixed-point constants of the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int FRAC_BITS = 28;
   localparam int VAL_BITS  = 40;
   localparam int OPND_BITS = 32;
   localparam int PROD_BITS = 2 * OPND_BITS;

   typedef logic signed [VAL_BITS-1:0]  val_type;
   typedef logic        [OPND_BITS-1:0] opnd_type;
   typedef logic        [PROD_BITS-1:0] prod_type;

   localparam val_type ONE       = val_type'(64'd1 << FRAC_BITS);
   localparam val_type QUARTER   = val_type'(64'd1 << (FRAC_BITS - 2));
   localparam val_type SIXTEENTH = val_type'(64'd1 << (FRAC_BITS - 4));
   localparam val_type FOUR      = val_type'(64'd4 << FRAC_BITS);
   localparam val_type CARD_LO   = -val_type'(64'd3 << (FRAC_BITS - 2));
   localparam val_type CARD_HI   = val_type'(64'd1 << (FRAC_BITS - 1));
   localparam val_type IM_BOUND  = val_type'(64'd2 << FRAC_BITS);

   localparam logic ADDR_MAX_ITER = 1'b0;

   typedef enum logic [3:0] {
      MUL_IM_IM,
      MUL_RE_RE,
      MUL_D_D,
      MUL_TR_TR,
      MUL_Q_QT,
      MUL_ZR_ZI,
      MUL_ZR_ZR,
      MUL_ZI_ZI
   } mul_op_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_IM2,
      WB_RE2,
      WB_D2,
      WB_Q,
      WB_QT,
      WB_FLAG,
      WB_ZUPD,
      WB_SR,
      WB_SI
   } wb_op_type;

   typedef struct packed {
      logic       load;
      mul_op_type mul_op;
      wb_op_type  wb_op;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_region;
      logic cont;
   } status_type;

endpackage
`default_nettype wire

[rtl/core/mbe_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_datapath
// Point registers, shared 32x32 magnitude multiplier, region tests, iterate
// registers, iteration counter and result register.
// ----------------------------------------------------------------------------
module mbe_datapath #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic signed [31:0]        req_point_real,
   input  wire logic signed [31:0]        req_point_imag,
   input  wire logic [COUNT_BITS-1:0]     limit,
   input  wire mbe_pkg::cmd_type          cmd,
   output mbe_pkg::status_type            status,
   output logic [COUNT_BITS-1:0]          rsp_iteration_count
);
   import mbe_pkg::*;

   function automatic opnd_type f_mag(input val_type v);
      val_type a;
      a = (v < 0) ? -v : v;
      return a[OPND_BITS-1:0];
   endfunction

   val_type re_ff, im_ff, d_ff, tr_ff;
   val_type im2_ff, re2_ff, d2_ff, q_ff, qt_ff;
   val_type zr_ff, zi_ff, sr_ff, si_ff;
   prod_type p_ff;
   logic neg_ff;
   logic inside_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic [COUNT_BITS-1:0] rsp_ff;

   val_type opa, opb, sc, re_in;
   logic disk1, disk2, card;

   always_comb begin
      opa = zr_ff;
      opb = zi_ff;
      case (cmd.mul_op)
         MUL_IM_IM: begin opa = im_ff; opb = im_ff; end
         MUL_RE_RE: begin opa = re_ff; opb = re_ff; end
         MUL_D_D:   begin opa = d_ff;  opb = d_ff;  end
         MUL_TR_TR: begin opa = tr_ff; opb = tr_ff; end
         MUL_Q_QT:  begin opa = q_ff;  opb = qt_ff; end
         MUL_ZR_ZR: begin opa = zr_ff; opb = zr_ff; end
         MUL_ZI_ZI: begin opa = zi_ff; opb = zi_ff; end
         default:   begin opa = zr_ff; opb = zi_ff; end
      endcase
   end

   assign sc    = neg_ff ? -val_type'(p_ff >> FRAC_BITS) : val_type'(p_ff >> FRAC_BITS);
   assign re_in = val_type'(req_point_real);
   assign disk1 = (re2_ff + im2_ff) < SIXTEENTH;
   assign disk2 = (d2_ff + im2_ff) < SIXTEENTH;
   assign card  = (re_ff > CARD_LO) && (re_ff < CARD_HI) && (im_ff > -IM_BOUND)
                  && (im_ff < IM_BOUND) && (sc < (im2_ff >>> 2));

   assign status.in_region = inside_ff;
   assign status.cont      = ((sr_ff + si_ff) < FOUR) && (n_ff < limit);
   assign rsp_iteration_count = rsp_ff;

   always_ff @(posedge clock) begin
      p_ff   <= PROD_BITS'(f_mag(opa)) * PROD_BITS'(f_mag(opb));
      neg_ff <= opa[VAL_BITS-1] ^ opb[VAL_BITS-1];
      if (cmd.load) begin
         re_ff <= re_in;
         im_ff <= val_type'(req_point_imag);
         d_ff  <= re_in + ONE;
         tr_ff <= re_in - QUARTER;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= inside_ff ? limit : n_ff;
      end
      unique case (cmd.wb_op)
         WB_NONE: ;
         WB_IM2:  im2_ff <= sc;
         WB_RE2:  re2_ff <= sc;
         WB_D2:   d2_ff  <= sc;
         WB_Q:    q_ff   <= sc + im2_ff;
         WB_QT:   qt_ff  <= q_ff + tr_ff;
         WB_FLAG: begin
            zr_ff <= '0;
            zi_ff <= '0;
            sr_ff <= '0;
            si_ff <= '0;
         end
         WB_ZUPD: begin
            zr_ff <= sr_ff - si_ff + re_ff;
            zi_ff <= (sc <<< 1) + im_ff;
         end
         WB_SR:   sr_ff <= sc;
         WB_SI:   si_ff <= sc;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         n_ff      <= '0;
      end else if (cmd.wb_op == WB_FLAG) begin
         inside_ff <= disk1 || disk2 || card;
         n_ff      <= '0;
      end else if (cmd.wb_op == WB_SI) begin
         n_ff <= n_ff + 1'b1;
      end
   end

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_op == WB_SI |=> n_ff == $past(n_ff) + 1'b1)
      else $error("iteration count did not advance");
   a_z_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.wb_op == WB_FLAG |=> (zr_ff == 0) && (zi_ff == 0) && (n_ff == 0))
      else $error("iterate not cleared");
   a_rsp_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load && inside_ff |=> rsp_ff == $past(limit))
      else $error("inside point did not return limit");

endmodule
`default_nettype wire

[rtl/core/mbe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: region checks, iteration loop, result handover.
// ----------------------------------------------------------------------------
module mbe_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire mbe_pkg::status_type status,
   output mbe_pkg::cmd_type         cmd
);
   import mbe_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE    = 15'b000000000000001,
      S_PRE_IM2 = 15'b000000000000010,
      S_PRE_RE2 = 15'b000000000000100,
      S_PRE_D2  = 15'b000000000001000,
      S_PRE_TR2 = 15'b000000000010000,
      S_PRE_Q   = 15'b000000000100000,
      S_PRE_QT  = 15'b000000001000000,
      S_PRE_LHS = 15'b000000010000000,
      S_PRE_DEC = 15'b000000100000000,
      S_CHK     = 15'b000001000000000,
      S_IT_TEST = 15'b000010000000000,
      S_IT_SQR  = 15'b000100000000000,
      S_IT_WBR  = 15'b001000000000000,
      S_IT_WBI  = 15'b010000000000000,
      S_DONE    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.mul_op   = MUL_ZR_ZI;
      cmd.wb_op    = WB_NONE;
      cmd.rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_PRE_IM2;
         end
         S_PRE_IM2: begin
            cmd.mul_op = MUL_IM_IM;
            state_in   = S_PRE_RE2;
         end
         S_PRE_RE2: begin
            cmd.wb_op  = WB_IM2;
            cmd.mul_op = MUL_RE_RE;
            state_in   = S_PRE_D2;
         end
         S_PRE_D2: begin
            cmd.wb_op  = WB_RE2;
            cmd.mul_op = MUL_D_D;
            state_in   = S_PRE_TR2;
         end
         S_PRE_TR2: begin
            cmd.wb_op  = WB_D2;
            cmd.mul_op = MUL_TR_TR;
            state_in   = S_PRE_Q;
         end
         S_PRE_Q: begin
            cmd.wb_op = WB_Q;
            state_in  = S_PRE_QT;
         end
         S_PRE_QT: begin
            cmd.wb_op = WB_QT;
            state_in  = S_PRE_LHS;
         end
         S_PRE_LHS: begin
            cmd.mul_op = MUL_Q_QT;
            state_in   = S_PRE_DEC;
         end
         S_PRE_DEC: begin
            cmd.wb_op = WB_FLAG;
            state_in  = S_CHK;
         end
         S_CHK: begin
            cmd.mul_op = MUL_ZR_ZI;
            state_in   = status.in_region ? S_DONE : S_IT_TEST;
         end
         S_IT_TEST: begin
            if (status.cont) begin
               cmd.wb_op = WB_ZUPD;
               state_in  = S_IT_SQR;
            end else begin
               state_in  = S_DONE;
            end
         end
         S_IT_SQR: begin
            cmd.mul_op = MUL_ZR_ZR;
            state_in   = S_IT_WBR;
         end
         S_IT_WBR: begin
            cmd.wb_op  = WB_SR;
            cmd.mul_op = MUL_ZI_ZI;
            state_in   = S_IT_WBI;
         end
         S_IT_WBI: begin
            cmd.wb_op  = WB_SI;
            cmd.mul_op = MUL_ZR_ZI;
            state_in   = S_IT_TEST;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PRE_IM2)
      else $error("accepted beat did not start checks");
   a_done_hands_over: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not handed over");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready)
      else $error("ready while busy");

endmodule
`default_nettype wire

[rtl/core/mandelbrot_escape_time.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one complex point with disk and cardioid pre-checks.
// ----------------------------------------------------------------------------
// One point is worked on at a time. A point that falls in a known region
// skips the iteration loop; otherwise the loop runs n times for a count of n:
// every iteration needs three products from the single shared 32x32
// multiplier, each held in the product register before it is written back.
// The result sits in an output register, so a new point is accepted as soon
// as the previous one has been handed over or moved into that register.
module mandelbrot_escape_time #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic signed [31:0]    req_point_real,
   input  wire logic signed [31:0]    req_point_imag,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COUNT_BITS-1:0]      rsp_iteration_count,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import mbe_pkg::*;

   localparam logic [31:0] ITER_RESET = 32'd524288;

   logic [COUNT_BITS-1:0] max_iter_ff;
   cmd_type    cmd;
   status_type status;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ADDR_MAX_ITER) ? 32'(max_iter_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITER_RESET[COUNT_BITS-1:0];
      end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_MAX_ITER) begin
         max_iter_ff <= pwdata[COUNT_BITS-1:0];
      end
   end

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_point_real      (req_point_real),
      .req_point_imag      (req_point_imag),
      .limit               (max_iter_ff),
      .cmd                 (cmd),
      .status              (status),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Escape-time block testbench: points in, iteration counts out.
// A local fixed-point predictor works out the count for each point that is
// accepted. Each returned count is checked against the oldest prediction
// still waiting. The iteration limit is rewritten between phases, with both
// extremes covered. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import mbe_pkg::*;

   localparam int           CNT_W     = 24;
   localparam logic [2:0]   LIMIT_ADDR = 3'd0;
   localparam longint       SAT_LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint       Q_ONE     = 64'sd1 << 28;
   localparam int           IDLE_CAP  = 20000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [31:0]      req_point_real;
   logic signed [31:0]      req_point_imag;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [CNT_W-1:0]        rsp_iteration_count;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [2:0]              paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   logic [CNT_W-1:0]        iter_limit;
   logic [CNT_W-1:0]        count_q[$];
   int                      errors;
   int                      stall;
   int                      idle_cycles;
   bit                      no_idle;

   mandelbrot_escape_time #(.COUNT_BITS(CNT_W)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_real(req_point_real), .req_point_imag(req_point_imag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_iteration_count(rsp_iteration_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] mag(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      logic [127:0] p;
      longint       m;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      p = p >> 28;
      m = (p > 128'(SAT_LIM)) ? SAT_LIM : longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -m : m;
   endfunction

   function automatic longint fx_add(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > SAT_LIM) return SAT_LIM;
      if (s < -SAT_LIM) return -SAT_LIM;
      return s;
   endfunction

   function automatic bit in_known_region(input longint re, input longint im);
      longint im2;
      longint d;
      longint tr;
      longint q;
      im2 = fx_mul(im, im);
      d   = re + Q_ONE;
      if (fx_add(fx_mul(re, re), im2) < (Q_ONE >>> 4)) return 1'b1;
      if (fx_add(fx_mul(d, d), im2) < (Q_ONE >>> 4)) return 1'b1;
      if (re > -(3 * (Q_ONE >>> 2)) && re < (Q_ONE >>> 1)) begin
         tr = re - (Q_ONE >>> 2);
         q  = fx_add(fx_mul(tr, tr), im2);
         if (fx_mul(q, fx_add(q, tr)) < (im2 >>> 2)) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [CNT_W-1:0] escape_count(input logic signed [31:0] cre,
                                                     input logic signed [31:0] cim,
                                                     input logic [CNT_W-1:0] lim);
      longint cr, ci, zr, zi, sr, si, m;
      int unsigned n;
      cr = cre;
      ci = cim;
      if (in_known_region(cr, ci)) return lim;
      zr = 0; zi = 0; sr = 0; si = 0; n = 0;
      while (fx_add(sr, si) < (Q_ONE <<< 2) && n < lim) begin
         m  = fx_mul(zr, zi);
         zr = fx_add(fx_add(sr, -si), cr);
         zi = fx_add(fx_add(m, m), ci);
         sr = fx_mul(zr, zr);
         si = fx_mul(zi, zi);
         n++;
      end
      return n[CNT_W-1:0];
   endfunction

   // predict on accept, check on result, stall the result side
   always @(posedge clock) begin
      logic [CNT_W-1:0] want;
      if (!reset) begin
         if (req_valid && req_ready)
            count_q.push_back(escape_count(req_point_real, req_point_imag, iter_limit));
         if (rsp_valid && rsp_ready) begin
            if (count_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat: count %0d", rsp_iteration_count);
            end else begin
               want = count_q.pop_front();
               if (want !== rsp_iteration_count) begin
                  errors++;
                  if (errors <= 10)
                     $display("count mismatch: expected %0d actual %0d", want,
                              rsp_iteration_count);
               end
            end
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall > 0) rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            if (stall == 0) rsp_ready <= 1'b1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_CAP) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_point_real <= re;
      req_point_imag <= im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (count_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] lim);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; paddr <= LIMIT_ADDR; pwdata <= 32'(lim);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      iter_limit = lim;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[CNT_W-1:0] !== lim) begin
         errors++;
         if (errors <= 10) $display("limit readback: expected %0d actual %0d", lim, prdata);
      end
      psel <= 1'b0; penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] fx(input real v);
      return 32'(longint'(v * 268435456.0));
   endfunction

   // fast points only: the reset limit is large
   task automatic test_reset_limit;
      send_point(32'sd0, 32'sd0);
      send_point(fx(-1.0), fx(0.1));
      send_point(fx(0.2), fx(0.3));
      send_point(fx(2.5), fx(2.5));
      send_point(fx(1.0), 32'sd0);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
   endtask

   task automatic test_special_points;
      write_limit(24'd40);
      send_point(fx(0.25), 32'sd0);
      send_point(fx(-0.75), 32'sd0);
      send_point(fx(0.5), 32'sd0);
      send_point(fx(-0.75) + 1, fx(0.01));
      send_point(fx(0.25), fx(0.01));
      send_point(fx(-1.25), 32'sd0);
      send_point(fx(0.0), fx(0.25));
      send_point(fx(-2.0), 32'sd0);
      send_point(32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(32'sd0, 32'sh8000_0000);
      send_point(fx(-0.1), fx(0.9));
      write_limit(24'd0);
      send_point(fx(2.0), fx(2.0));
      send_point(32'sd0, 32'sd0);
      write_limit(24'd1);
      send_point(fx(-0.5), fx(0.6));
      send_point(fx(3.0), 32'sd0);
   endtask

   task automatic test_max_limit;
      write_limit(24'hFF_FFFF);
      send_point(fx(0.1), fx(-0.1));
      send_point(fx(-1.1), fx(0.05));
      send_point(fx(1.5), fx(1.5));
      send_point(fx(-2.5), fx(0.5));
   endtask

   task automatic test_random(input logic [CNT_W-1:0] lim, input int n);
      logic signed [31:0] re, im;
      int                 pick;
      write_limit(lim);
      repeat (n) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            re = -32'sd603979776 + 32'($urandom_range(0, 805306368));
            im = -32'sd402653184 + 32'($urandom_range(0, 805306368));
         end else if (pick < 8) begin
            re = $urandom;
            im = $urandom;
         end else begin
            re = fx(-0.75) + 32'($urandom_range(0, 4096)) - 32'sd2048;
            im = 32'($urandom_range(0, 65536)) - 32'sd32768;
         end
         send_point(re, im);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_point_real = '0; req_point_imag = '0;
      rsp_ready = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      iter_limit = 24'd524288;
      errors = 0; stall = 0; idle_cycles = 0; no_idle = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_limit();
      test_special_points();
      test_max_limit();
      test_random(24'd1, 80);
      test_random(24'd16, 100);
      no_idle = 1'b1;
      test_random(24'd64, 100);
      no_idle = 1'b0;
      test_random(24'd255, 100);
      test_random(24'd300, 100);
      test_random(24'd7, 80);
      drain();
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
